// ===== src/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and the byte-serial CRC-32 step for the packet
// frame checker.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int unsigned HDR_BYTES  = 20;
    localparam int unsigned HDR_WORDS  = 5;
    localparam int unsigned MIN_BYTES  = 24;
    localparam int unsigned CRC_START  = 4;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

    localparam int unsigned WORD_CRC   = 0;
    localparam int unsigned WORD_ID    = 1;
    localparam int unsigned WORD_COUNT = 2;
    localparam int unsigned WORD_INDEX = 3;
    localparam int unsigned WORD_SIZE  = 4;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SHORT     = 3'd1,
        ERR_LONG      = 3'd2,
        ERR_SIZE      = 3'd3,
        ERR_TAIL      = 3'd4,
        ERR_CRC       = 3'd5
    } err_code_t;

    typedef logic [31:0] word_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/packet_frame_checker.sv =====
// ----------------------------------------------------------------------------
// packet_frame_checker
// Checks a received packet, one byte per transfer, and reports one verdict
// with the header fields on the byte that carries the last marker.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  data      data_valid, data_stall, data_byte, last   in
//  result    result_valid, result_stall, ok, ...       out
//
// One byte is taken per cycle while data_stall is low; each byte passes an
// input register and then the CRC step, header capture and checks into the
// result register. The CRC byte step is the longest path. Reset clears the
// valid flags and packet state. A stalled result holds only a last byte in
// the input register, stalling the input; other bytes pass regardless.
//
module packet_frame_checker #(
    parameter int unsigned MAX_PACKET_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               data_valid,
    output logic               data_stall,
    input  logic [7:0]         data_byte,
    input  logic               last,

    output logic               result_valid,
    input  logic               result_stall,
    output logic               ok,
    output logic [2:0]         error_code,
    output logic [31:0]        frame_id,
    output logic signed [31:0] seq_count,
    output logic signed [31:0] seq_index,
    output logic [12:0]        payload_bytes,
    output logic               seq_start,
    output logic               seq_end
);

    localparam int unsigned CW = $clog2(MAX_PACKET_BYTES + 2);
    localparam logic [CW-1:0] MIN_CNT   = CW'(pfc_pkg::MIN_BYTES);
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_PACKET_BYTES);
    localparam logic [CW-1:0] HDR_CNT   = CW'(pfc_pkg::HDR_BYTES);
    localparam logic [CW-1:0] CRC_CNT   = CW'(pfc_pkg::CRC_START);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;

    logic [CW-1:0]      count_reg, count_next;
    logic [31:0]        crc_reg, crc_next;
    pfc_pkg::word_t     hdr_reg [pfc_pkg::HDR_WORDS];
    pfc_pkg::word_t     hdr_next [pfc_pkg::HDR_WORDS];
    logic [31:0]        recent_reg, recent_next;

    logic               out_valid_reg, out_valid_next;
    logic               ok_reg;
    pfc_pkg::err_code_t err_reg;
    logic [31:0]        id_reg;
    logic [31:0]        count_word_reg;
    logic [31:0]        index_word_reg;
    logic [12:0]        pay_reg;
    logic               start_reg;
    logic               end_reg;

    logic               data_take;
    logic               out_free;
    logic               proc_go;
    logic               verdict;

    logic [CW-1:0]      len;
    logic [CW-1:0]      pay;
    logic [CW-1:0]      pay_out;
    pfc_pkg::err_code_t err;
    logic               cnt_pos;
    logic               seq_start_c;
    logic               seq_end_c;
    logic signed [32:0] cnt_ext;
    logic signed [32:0] idx_plus;

    assign out_free   = !out_valid_reg || !result_stall;
    assign proc_go    = in_valid_reg && (!in_last_reg || out_free);
    assign verdict    = proc_go && in_last_reg;
    assign data_stall = in_valid_reg && !proc_go;
    assign data_take  = data_valid && !data_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (data_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_go)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Packet state update for the byte in the input register.
    always_comb
    begin
        for (int i = 0; i < pfc_pkg::HDR_WORDS; i++)
        begin
            hdr_next[i] = hdr_reg[i];
        end
        if (count_reg < HDR_CNT)
        begin
            hdr_next[count_reg[4:2]][count_reg[1:0]*8 +: 8] = in_byte_reg;
        end
        crc_next = crc_reg;
        if (count_reg >= CRC_CNT)
        begin
            crc_next = pfc_pkg::crc_byte(crc_reg, in_byte_reg);
        end
        recent_next = {recent_reg[23:0], in_byte_reg};
        count_next  = count_reg;
        if (count_reg <= MAX_CNT)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    // Verdict on the updated state.
    always_comb
    begin
        len     = count_next;
        pay     = len - MIN_CNT;
        pay_out = '0;
        if (len < MIN_CNT)
        begin
            err = pfc_pkg::ERR_SHORT;
        end
        else if (len > MAX_CNT)
        begin
            err = pfc_pkg::ERR_LONG;
        end
        else
        begin
            pay_out = pay;
            if (hdr_next[pfc_pkg::WORD_SIZE] != 32'(pay))
            begin
                err = pfc_pkg::ERR_SIZE;
            end
            else if (recent_next[31:24] != 8'd0)
            begin
                err = pfc_pkg::ERR_TAIL;
            end
            else if (~crc_next != hdr_next[pfc_pkg::WORD_CRC])
            begin
                err = pfc_pkg::ERR_CRC;
            end
            else
            begin
                err = pfc_pkg::ERR_NONE;
            end
        end

        cnt_ext  = {hdr_next[pfc_pkg::WORD_COUNT][31], hdr_next[pfc_pkg::WORD_COUNT]};
        idx_plus = $signed({hdr_next[pfc_pkg::WORD_INDEX][31],
                            hdr_next[pfc_pkg::WORD_INDEX]}) + 33'sd1;
        cnt_pos     = !cnt_ext[32] && (cnt_ext != 33'sd0);
        seq_start_c = cnt_pos && (hdr_next[pfc_pkg::WORD_INDEX] == 32'd0);
        seq_end_c   = !cnt_pos || (idx_plus >= cnt_ext);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (verdict)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            crc_reg       <= pfc_pkg::CRC_INIT;
            recent_reg    <= '0;
            for (int i = 0; i < pfc_pkg::HDR_WORDS; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc_go)
            begin
                if (in_last_reg)
                begin
                    count_reg  <= '0;
                    crc_reg    <= pfc_pkg::CRC_INIT;
                    recent_reg <= '0;
                    for (int i = 0; i < pfc_pkg::HDR_WORDS; i++)
                    begin
                        hdr_reg[i] <= '0;
                    end
                end
                else
                begin
                    count_reg  <= count_next;
                    crc_reg    <= crc_next;
                    recent_reg <= recent_next;
                    for (int i = 0; i < pfc_pkg::HDR_WORDS; i++)
                    begin
                        hdr_reg[i] <= hdr_next[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_take)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last;
        end
        if (verdict)
        begin
            ok_reg         <= (err == pfc_pkg::ERR_NONE);
            err_reg        <= err;
            id_reg         <= (err == pfc_pkg::ERR_NONE) ? hdr_next[pfc_pkg::WORD_ID] : 32'd0;
            count_word_reg <= hdr_next[pfc_pkg::WORD_COUNT];
            index_word_reg <= hdr_next[pfc_pkg::WORD_INDEX];
            pay_reg        <= 13'(pay_out);
            start_reg      <= seq_start_c;
            end_reg        <= seq_end_c;
        end
    end

    assign result_valid  = out_valid_reg;
    assign ok            = ok_reg;
    assign error_code    = err_reg;
    assign frame_id      = id_reg;
    assign seq_count     = $signed(count_word_reg);
    assign seq_index     = $signed(index_word_reg);
    assign payload_bytes = pay_reg;
    assign seq_start     = start_reg;
    assign seq_end       = end_reg;

`ifndef SYNTHESIS
    assert_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (ok == (error_code == pfc_pkg::ERR_NONE)))
        else $error("ok flag disagrees with error code");

    assert_id_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !ok) |-> (frame_id == 32'd0))
        else $error("packet id shown on a failed packet");

    assert_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        data_stall |-> (in_valid_reg && in_last_reg && out_valid_reg && result_stall))
        else $error("input stalled without a blocked verdict");

    assert_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        verdict |=> (count_reg == '0 && crc_reg == pfc_pkg::CRC_INIT))
        else $error("packet state not cleared after verdict");
`endif

endmodule
